// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker file.
// No dependencies; include guard below.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dltq_pkg.sv -----
// Types and codes for the delta-list timer queue.
// No dependencies; used by every other file of the block but assert_macros.svh.
package dltq_pkg;

  localparam logic       CMD_INSERT = 1'b0;
  localparam logic       CMD_TICK   = 1'b1;

  localparam logic [1:0] KIND_EXPIRY    = 2'd0;
  localparam logic [1:0] KIND_ACCEPT    = 2'd1;
  localparam logic [1:0] KIND_REJECT    = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE = 2'd3;

  localparam logic [1:0] REG_TICK_AMOUNT = 2'd0;
  localparam logic [1:0] REG_HIGH_WATER  = 2'd1;

  localparam logic [31:0] TICK_AMOUNT_RESET = 32'd100000;
  localparam logic [5:0]  HIGH_WATER_RESET  = 6'd20;

  typedef struct packed {
    logic        command;
    logic [31:0] delay;
    logic [15:0] client_tag;
    logic [15:0] response_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] expired_client;
    logic [15:0] expired_code;
    logic [5:0]  pending_count;
    logic        over_high_water;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] delta;
    logic [15:0] client;
    logic [15:0] code;
  } entry_t;

  typedef struct packed {
    logic        le;
    logic [31:0] diff;
  } sub_res_t;

endpackage

// ----- design/dltq_cmpsub.sv -----
// Shared compare/subtract unit of the timer queue sequencer.
// Depends on dltq_pkg (sub_res_t).
module dltq_cmpsub (
  input  logic [31:0]       rem,
  input  logic [31:0]       delta,
  input  logic              swap,
  output dltq_pkg::sub_res_t res
);
  import dltq_pkg::*;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [32:0] wide;

  // swap = 0: rem - delta, le means delta <= rem
  assign op_a = swap ? delta : rem;
  assign op_b = swap ? rem : delta;
  assign wide = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff = wide[31:0];
  assign res.le   = ~wide[32];

endmodule

// ----- design/delta_list_timer_queue.sv -----
// Delta-list timer queue: sequencer, entry memory, config registers.
// Depends on dltq_pkg and dltq_cmpsub.
//
// channel | dir    | handshake             | payload
// in_     | input  | in_valid / in_ready   | in_item_t (command, delay, tag, code)
// out_    | output | out_valid / out_ready | out_item_t (one per result)
// cfg_    | input  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Insert into n entries: walk reads, then tail shift, both through the single
// memory read port. Tick: scans s entries, then emits e expired ones, and can
// wait on output stalls. One item at a time; in_ready only idle.
// Output register lets the last result wait while the next item is taken.
// Reset (rst_n, synchronous) empties the queue; no memory clearing pass.
module delta_list_timer_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dltq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dltq_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import dltq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = (CW > 6) ? CW : 6;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_IREAD  = 4'd1;
  localparam logic [3:0] S_ICMP   = 4'd2;
  localparam logic [3:0] S_IFOL   = 4'd3;
  localparam logic [3:0] S_SHRD   = 4'd4;
  localparam logic [3:0] S_SHWR   = 4'd5;
  localparam logic [3:0] S_INEW   = 4'd6;
  localparam logic [3:0] S_TREAD  = 4'd7;
  localparam logic [3:0] S_TCMP   = 4'd8;
  localparam logic [3:0] S_THEAD  = 4'd9;
  localparam logic [3:0] S_EREAD  = 4'd10;
  localparam logic [3:0] S_EOUT   = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   tick_amount_r;
  logic [5:0]    high_water_r;

  logic [15:0]   cli_r;
  logic [15:0]   code_r;
  entry_t        fol_r, fol_nxt;

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          out_load;
  out_item_t     out_load_data;
  logic          out_free;

  logic          sub_swap;
  sub_res_t      sub_res;
  logic [HW-1:0] cnt_ext;
  logic          over_hw;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(head) + (CW + 1)'(off);
    if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
      s = s - (CW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dltq_cmpsub u_cmpsub (
    .rem   (rem_r),
    .delta (rd_data_r.delta),
    .swap  (sub_swap),
    .res   (sub_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = ~out_valid_r | out_ready;
  assign cnt_ext   = HW'(count_r);
  assign over_hw   = cnt_ext > HW'(high_water_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    kind_nxt      = kind_r;
    fol_nxt       = fol_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    sub_swap      = 1'b0;
    out_load      = 1'b0;
    out_load_data = '0;
    out_load_data.pending_count   = cnt_ext[5:0];
    out_load_data.over_high_water = over_hw;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt = '0;
          if (in_data.command == CMD_TICK) begin
            rem_nxt   = tick_amount_r;
            state_nxt = S_TREAD;
          end else if (count_r == CW'(QUEUE_DEPTH)) begin
            kind_nxt  = KIND_REJECT;
            state_nxt = S_RESULT;
          end else begin
            rem_nxt   = in_data.delay;
            state_nxt = S_IREAD;
          end
        end
      end
      S_IREAD: begin
        if (k_r == count_r) begin
          state_nxt = S_INEW;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, k_r);
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        if (sub_res.le) begin
          rem_nxt   = sub_res.diff;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_IREAD;
        end else begin
          state_nxt = S_IFOL;
        end
      end
      S_IFOL: begin
        sub_swap      = 1'b1;
        fol_nxt       = rd_data_r;
        fol_nxt.delta = sub_res.diff;
        j_nxt         = count_r;
        state_nxt     = S_SHRD;
      end
      S_SHRD: begin
        if (j_r == k_r + 1'b1) begin
          wr_en     = 1'b1;
          wr_addr   = phys(head_r, j_r);
          wr_data   = fol_r;
          state_nxt = S_INEW;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, j_r - 1'b1);
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = phys(head_r, j_r);
        wr_data   = rd_data_r;
        j_nxt     = j_r - 1'b1;
        state_nxt = S_SHRD;
      end
      S_INEW: begin
        wr_en          = 1'b1;
        wr_addr        = phys(head_r, k_r);
        wr_data.delta  = rem_r;
        wr_data.client = cli_r;
        wr_data.code   = code_r;
        count_nxt      = count_r + 1'b1;
        kind_nxt       = KIND_ACCEPT;
        state_nxt      = S_RESULT;
      end
      S_TREAD: begin
        if (k_r == count_r) begin
          count_nxt = '0;
          state_nxt = S_EREAD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, k_r);
          state_nxt = S_TCMP;
        end
      end
      S_TCMP: begin
        if (sub_res.le) begin
          rem_nxt   = sub_res.diff;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TREAD;
        end else begin
          state_nxt = S_THEAD;
        end
      end
      S_THEAD: begin
        sub_swap      = 1'b1;
        wr_en         = 1'b1;
        wr_addr       = phys(head_r, k_r);
        wr_data       = rd_data_r;
        wr_data.delta = sub_res.diff;
        count_nxt     = count_r - k_r;
        state_nxt     = S_EREAD;
      end
      S_EREAD: begin
        if (k_r == '0) begin
          kind_nxt  = KIND_TICK_DONE;
          state_nxt = S_RESULT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = head_r;
          state_nxt = S_EOUT;
        end
      end
      S_EOUT: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_load_data.kind           = KIND_EXPIRY;
          out_load_data.expired_client = rd_data_r.client;
          out_load_data.expired_code   = rd_data_r.code;
          head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          k_nxt     = k_r - 1'b1;
          state_nxt = S_EREAD;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_load_data.kind = kind_r;
          out_load_data.last = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      k_r         <= '0;
      j_r         <= '0;
      rem_r       <= '0;
      kind_r      <= KIND_ACCEPT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      rem_r   <= rem_nxt;
      kind_r  <= kind_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_amount_r <= TICK_AMOUNT_RESET;
      high_water_r  <= HIGH_WATER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TICK_AMOUNT: tick_amount_r <= cfg_data;
        REG_HIGH_WATER:  high_water_r  <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fol_r <= fol_nxt;
    if (in_valid && in_ready) begin
      cli_r  <= in_data.client_tag;
      code_r <= in_data.response_code;
    end
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- design/dltq_checker.sv -----
// Port-level checks for the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dltq_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dltq_pkg::out_item_t out_data
);
  import dltq_pkg::*;

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out stall lost")

  // one item at a time
  `ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")

  // only the closing result of an item carries last
  `ASSERT_NOW(a_last_kind, out_valid, out_data.last == (out_data.kind != KIND_EXPIRY), "last/kind mismatch")

  // reject only when full
  `ASSERT_NOW(a_reject_full, out_valid && (out_data.kind == KIND_REJECT), out_data.pending_count == 6'(QUEUE_DEPTH), "reject while not full")

endmodule

bind delta_list_timer_queue dltq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dltq_checker (.*);
